>>> src/smv_pkg.sv
// Package for the softmax vector unit: constants, types and controller commands.
package smv_pkg;

    localparam int MaxLenDefault = 64;
    localparam int ScoreW        = 16;
    localparam int ExpW          = 17;
    localparam int SumW          = 23;
    localparam int ProbW         = 16;
    localparam int TaylorTerms   = 10;
    localparam logic [29:0] Ln2Q30 = 30'd744261118;
    localparam logic [30:0] OneQ30 = 31'd1073741824;

    // Controller states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EXP_RD,
        ST_EXP_RED,
        ST_EXP_TAY,
        ST_EXP_FIN,
        ST_DIV_RD,
        ST_DIV_RUN,
        ST_DIV_POST,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // store an incoming score
        logic exp_rd;      // read score for exp pass, latch max minus score
        logic red_step;    // one step of range reduction
        logic tay_step;    // one Taylor half step (multiply or divide)
        logic exp_fin;     // finish exponential, write exp_store, accumulate
        logic div_rd;      // read exp value, start divide
        logic div_step;    // load numerator, else one quotient bit
        logic div_post;    // saturate and mode-apply
        logic clr;         // clear vector state
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic red_done;
        logic tay_done;
        logic div_done;
    } t_stat;

endpackage

>>> src/smv_datapath.sv
// Datapath of the softmax vector unit: stores, exponential and divider units.
module smv_datapath #(
    parameter int MAX_LEN = smv_pkg::MaxLenDefault,
    parameter int IW      = $clog2(MAX_LEN)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  smv_pkg::t_cmd              i_cmd,
    input  logic [IW-1:0]              i_idx,
    input  logic signed [15:0]         i_score,
    input  logic                       i_mode,
    output smv_pkg::t_stat             o_stat,
    output logic [15:0]                o_prob
);

    // Memories
    logic signed [15:0] r_score_mem [MAX_LEN];
    logic [16:0]        r_exp_mem   [MAX_LEN];
    logic signed [15:0] r_score_rd;
    logic [16:0]        r_exp_rd;

    logic signed [15:0] r_max;
    logic [22:0]        r_sum;

    // Exponential unit registers
    logic [35:0] r_z;       // remainder during reduction
    logic [4:0]  r_k;
    logic [30:0] r_term;
    logic [31:0] r_acc;     // signed-ish accumulate, stays positive
    logic [3:0]  r_i;
    logic        r_big;
    logic [30:0] r_x;       // truncated product of the current term
    logic        r_ph;      // Taylor half step: 0 multiply, 1 divide

    // Divider registers
    logic [32:0] r_num;
    logic [23:0] r_rem;
    logic [16:0] r_q;
    logic [5:0]  r_bit;
    logic [15:0] r_prob;

    logic [16:0] w_e;
    logic [32:0] w_sh;
    logic [60:0] w_prod;
    logic [30:0] w_tq;
    logic [30:0] w_rm;
    logic [5:0]  w_rs;
    logic [61:0] w_rp;
    logic [23:0] w_trial;

    // Score and exp stores, and running max
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_score_mem[i_idx] <= i_score;
        end
        r_score_rd <= r_score_mem[i_idx];
        if (i_cmd.exp_fin) begin
            r_exp_mem[i_idx] <= w_e;
        end
        r_exp_rd <= r_exp_mem[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_max <= -16'sd32768;
        end else if (i_cmd.load && i_score > r_max) begin
            r_max <= i_score;
        end
    end

    // Taylor term: multiply by r, then divide by the term index
    // through a reciprocal multiply (exact for products below 2^30)
    assign w_prod = 61'(r_term) * 61'(r_z[29:0]);
    always_comb begin
        case (r_i)
            4'd1:    begin w_rm = 31'd1;          w_rs = 6'd0;  end
            4'd2:    begin w_rm = 31'd1;          w_rs = 6'd1;  end
            4'd3:    begin w_rm = 31'd1431655766; w_rs = 6'd32; end
            4'd4:    begin w_rm = 31'd1;          w_rs = 6'd2;  end
            4'd5:    begin w_rm = 31'd1717986919; w_rs = 6'd33; end
            4'd6:    begin w_rm = 31'd1431655766; w_rs = 6'd33; end
            4'd7:    begin w_rm = 31'd1227133514; w_rs = 6'd33; end
            4'd8:    begin w_rm = 31'd1;          w_rs = 6'd3;  end
            4'd9:    begin w_rm = 31'd1908874354; w_rs = 6'd34; end
            default: begin w_rm = 31'd1717986919; w_rs = 6'd34; end
        endcase
    end
    assign w_rp = 62'(r_x) * 62'(w_rm);
    assign w_tq = 31'(w_rp >> w_rs);

    // Final rounding shift
    assign w_sh = (33'(r_acc) + (33'd1 << (13 + r_k))) >> (14 + r_k);
    assign w_e  = r_big ? 17'd0 : ((w_sh > 33'd65536) ? 17'd65536 : w_sh[16:0]);

    // Exponential unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_rd) begin
            r_z    <= {20'(16'(r_max - r_score_rd)), 16'd0} << 4;
            r_k    <= '0;
            r_big  <= 1'b0;
            r_term <= smv_pkg::OneQ30;
            r_acc  <= 32'(smv_pkg::OneQ30);
            r_i    <= 4'd1;
            r_ph   <= 1'b0;
        end else if (i_cmd.red_step) begin
            if (r_z >= 36'(smv_pkg::Ln2Q30)) begin
                r_z <= r_z - 36'(smv_pkg::Ln2Q30);
                if (r_k == 5'd16) begin
                    r_big <= 1'b1;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
        end else if (i_cmd.tay_step) begin
            if (!r_ph) begin
                r_x  <= w_prod[60:30];
                r_ph <= 1'b1;
            end else begin
                r_term <= w_tq;
                r_acc  <= r_i[0] ? r_acc - 32'(w_tq) : r_acc + 32'(w_tq);
                r_i    <= r_i + 4'd1;
                r_ph   <= 1'b0;
            end
        end
    end

    // Sum of exponentials
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr || i_cmd.exp_rd && i_idx == '0) begin
            r_sum <= '0;
        end else if (i_cmd.exp_fin) begin
            r_sum <= r_sum + 23'(w_e);
        end
    end

    // Restoring divider, one bit a cycle
    assign w_trial = {r_rem[22:0], r_num[32]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_rd) begin
            r_num <= '0;
            r_rem <= '0;
            r_bit <= '0;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_bit == 6'd0) begin
                r_num <= {r_exp_rd, 16'd0} + 33'(r_sum >> 1);
                r_bit <= 6'd1;
            end else begin
                r_num <= {r_num[31:0], 1'b0};
                if (r_sum != '0 && w_trial >= 24'(r_sum)) begin
                    r_rem <= w_trial - 24'(r_sum);
                    r_q   <= (r_q << 1) | 17'd1;
                end else begin
                    r_rem <= w_trial;
                    r_q   <= r_q << 1;
                end
                r_bit <= r_bit + 6'd1;
            end
        end else if (i_cmd.div_post) begin
            if (r_sum == '0) begin
                r_q <= '0;
            end
        end
    end

    // Quotient may exceed 17 bits only in overflow of the cap; track saturation
    logic r_qsat;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_rd) begin
            r_qsat <= 1'b0;
        end else if (i_cmd.div_step && r_bit != 6'd0 && r_q[16]) begin
            r_qsat <= 1'b1;
        end
    end

    logic [16:0] w_qc;
    assign w_qc = (r_qsat || r_q > 17'd65536) ? 17'd65536 : r_q;
    logic [33:0] w_dmc;
    assign w_dmc = 34'(w_qc) * 34'(17'd65536 - w_qc) + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_post) begin
            if (r_sum == '0) begin
                r_prob <= i_mode ? 16'd0 : 16'd0;
            end else if (i_mode) begin
                r_prob <= w_dmc[31:16];
            end else begin
                r_prob <= w_qc[16] ? 16'hFFFF : w_qc[15:0];
            end
        end
    end

    assign o_stat.red_done = (r_z < 36'(smv_pkg::Ln2Q30)) || r_big;
    assign o_stat.tay_done = (r_i == 4'(smv_pkg::TaylorTerms + 1));
    assign o_stat.div_done = (r_bit == 6'd34);
    assign o_prob = r_prob;

endmodule

>>> src/smv_ctrl.sv
// Controller of the softmax vector unit: load, exp pass, divide pass, output.
module smv_ctrl #(
    parameter int MAX_LEN = smv_pkg::MaxLenDefault,
    parameter int IW      = $clog2(MAX_LEN)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_last,
    input  logic               i_out_ready,
    input  smv_pkg::t_stat     i_stat,
    output smv_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]      o_idx,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic               o_eov,
    output logic               o_ovf
);

    localparam int CW = IW + 1;

    smv_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_ovf, n_ovf;
    logic          w_room;

    assign w_room = (r_cnt < CW'(MAX_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smv_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_ovf       = r_ovf;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_idx       = r_idx;
        case (r_state)
            smv_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                o_idx      = r_cnt[IW-1:0];
                if (i_in_fire) begin
                    if (w_room) begin
                        o_cmd.load = 1'b1;
                        n_cnt      = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_idx   = '0;
                        n_state = smv_pkg::ST_EXP_RD;
                    end
                end
            end
            smv_pkg::ST_EXP_RD: begin
                n_state = smv_pkg::ST_EXP_RED;
            end
            smv_pkg::ST_EXP_RED: begin
                if (r_idx == '0 && r_cnt == '0) begin
                    n_state = smv_pkg::ST_LOAD;
                end else begin
                    o_cmd.exp_rd = 1'b1;
                    n_state      = smv_pkg::ST_EXP_TAY;
                end
            end
            smv_pkg::ST_EXP_TAY: begin
                if (!i_stat.red_done) begin
                    o_cmd.red_step = 1'b1;
                end else if (!i_stat.tay_done) begin
                    o_cmd.tay_step = 1'b1;
                end else begin
                    n_state = smv_pkg::ST_EXP_FIN;
                end
            end
            smv_pkg::ST_EXP_FIN: begin
                o_cmd.exp_fin = 1'b1;
                if (CW'(r_idx) + CW'(1) == r_cnt) begin
                    n_idx   = '0;
                    n_state = smv_pkg::ST_DIV_RD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = smv_pkg::ST_EXP_RD;
                end
            end
            smv_pkg::ST_DIV_RD: begin
                o_cmd.div_rd = 1'b1;
                n_state      = smv_pkg::ST_DIV_RUN;
            end
            smv_pkg::ST_DIV_RUN: begin
                if (i_stat.div_done) begin
                    n_state = smv_pkg::ST_DIV_POST;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            smv_pkg::ST_DIV_POST: begin
                o_cmd.div_post = 1'b1;
                n_state        = smv_pkg::ST_OUT;
            end
            smv_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (CW'(r_idx) + CW'(1) == r_cnt) begin
                        o_cmd.clr = 1'b1;
                        n_idx     = '0;
                        n_cnt     = '0;
                        n_ovf     = 1'b0;
                        n_state   = smv_pkg::ST_LOAD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = smv_pkg::ST_DIV_RD;
                    end
                end
            end
            default: n_state = smv_pkg::ST_LOAD;
        endcase
    end

    assign o_eov = (CW'(r_idx) + CW'(1) == r_cnt);
    assign o_ovf = r_ovf;

endmodule

>>> src/softmax_vector_unit_top.sv
// Top level of the softmax vector unit.
//
// Input stream (s_axis): one signed Q6.10 score per transfer, tlast marks the
// final element of a vector. Up to MAX_LEN elements are stored; later ones
// are dropped and flagged. Output stream (m_axis): one unsigned Q0.16 result
// per stored element, in arrival order, tlast on the final one, tuser set on
// every result of a vector that overflowed.
// i_output_mode_we/i_output_mode_wdata write the mode register (0 softmax,
// 1 derivative s*(1-s)); it is sampled when the vector is processed.
// Loading accepts one element per cycle. After tlast, the exponential of every
// element is formed in the shared exponential unit by range reduction and Taylor
// terms (a multiply and a divide per term); then each element in turn passes
// the one-bit-per-cycle divider and its result is output. No new input is taken
// meanwhile.
// Reset (synchronous, active low) empties the vector and sets mode 0.
// When the receiver stalls, the current result holds and processing waits.
module softmax_vector_unit_top #(
    parameter int MAX_LEN = smv_pkg::MaxLenDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] score
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] prob_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] overflow_flag
    input  logic        i_output_mode_we,
    input  logic        i_output_mode_wdata
);

    localparam int IW = $clog2(MAX_LEN);

    smv_pkg::t_cmd  w_cmd;
    smv_pkg::t_stat w_stat;
    logic [IW-1:0]  w_idx;
    logic           r_mode;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_output_mode_we) begin
            r_mode <= i_output_mode_wdata;
        end
    end

    smv_ctrl #(.MAX_LEN(MAX_LEN), .IW(IW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (s_axis_tvalid && s_axis_tready),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_eov       (m_axis_tlast),
        .o_ovf       (m_axis_tuser)
    );

    smv_datapath #(.MAX_LEN(MAX_LEN), .IW(IW)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .i_score (s_axis_tdata),
        .i_mode  (r_mode),
        .o_stat  (w_stat),
        .o_prob  (m_axis_tdata)
    );

endmodule

>>> src/smv_checker.sv
// Port-level checker for the softmax vector unit, bound to the top level.
module smv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // No input taken while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while output valid");

    // Stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // After the last result the unit returns to loading
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready after vector end");

    // No output right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind softmax_vector_unit_top smv_checker u_smv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
